// File: rtl/fpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_pkg - shared types and constants of the filtered period counter
// Configuration register indexes, the configuration bundle and the result
// word that travels from the core to the output register.
// ----------------------------------------------------------------------------
package fpc_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TIMEOUT  = 2'd0,
		REG_WINDOW   = 2'd1,
		REG_POLARITY = 2'd2,
		REG_AVERAGE  = 2'd3
	} cfg_idx_t;

	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
	localparam logic [18:0] PERIOD_MAX    = 19'h7FFFF;

	typedef struct packed {
		logic [15:0] timeout_ticks;
		logic [7:0]  stable_window;
		logic        rising_polarity;
		logic        average_enable;
	} cfg_t;

	typedef struct packed {
		logic        edge_seen;
		logic        second_edge_seen;
		logic [15:0] half_duration;
		logic        period_changed;
		logic [18:0] period_value;
		logic        measuring;
	} result_t;

endpackage

// File: rtl/filtered_period_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filtered_period_counter - glitch filtered period counter
// Measures the period between chosen edges of a sampled pin, with optional
// window filter, averaging and timeout; one result word per sample word.
// ----------------------------------------------------------------------------
// Timing: the input register loads the sample word when it is accepted and holds
// it until the result register has room; out_valid rises when the result register loads.
// Throughput: one sample word per cycle while out_ready holds; a stalled output holds the word.
// Reset: arst_n clears all measurement state and empties both registers;
// configuration returns to timeout 1000, filter off, rising edges, no average.
module filtered_period_counter #(
	parameter int AVG_COUNT = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [fpc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fpc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            pin_level,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            edge_seen,
	output logic                            second_edge_seen,
	output logic [15:0]                     half_duration,
	output logic                            period_changed,
	output logic [18:0]                     period_value,
	output logic                            measuring
);
	import fpc_pkg::*;

	cfg_t    cfg;
	result_t res;
	result_t res_q;
	logic    valid_s1;
	logic    pin_s1;
	logic    out_valid_q;
	logic    adv;

	fpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// move the held word into the result register when there is room
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	fpc_core #(
		.AVG_COUNT (AVG_COUNT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.pin    (pin_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pin_s1 <= pin_level;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign edge_seen        = res_q.edge_seen;
	assign second_edge_seen = res_q.second_edge_seen;
	assign half_duration    = res_q.half_duration;
	assign period_changed   = res_q.period_changed;
	assign period_value     = res_q.period_value;
	assign measuring        = res_q.measuring;

`ifndef SYNTHESIS
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> valid_s1)
		else $error("held sample word lost while the output is stalled");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("result register not loaded after a core step");
`endif

endmodule

// File: rtl/fpc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_cfg - configuration register file
// Four write-only registers, loaded from the plain write port.
// ----------------------------------------------------------------------------
module fpc_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [fpc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fpc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output fpc_pkg::cfg_t                   cfg
);
	import fpc_pkg::*;

	cfg_t cfg_q;

	// decode the index and load the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks   <= TIMEOUT_RESET;
			cfg_q.stable_window   <= '0;
			cfg_q.rising_polarity <= 1'b1;
			cfg_q.average_enable  <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_TIMEOUT:  cfg_q.timeout_ticks   <= cfg_data;
				REG_WINDOW:   cfg_q.stable_window   <= cfg_data[7:0];
				REG_POLARITY: cfg_q.rising_polarity <= cfg_data[0];
				REG_AVERAGE:  cfg_q.average_enable  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/fpc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_core - measurement state and single-pass update
// Holds the tick counter, glitch filter window, edge timing and averaging
// state; one pin sample is folded in whenever step is high.
// ----------------------------------------------------------------------------
module fpc_core #(
	parameter int AVG_COUNT = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             pin,
	input  fpc_pkg::cfg_t    cfg,
	output fpc_pkg::result_t res
);
	import fpc_pkg::*;

	localparam int          IdxW    = (AVG_COUNT > 1) ? $clog2(AVG_COUNT) : 1;
	localparam logic [IdxW-1:0] IdxLast = IdxW'(AVG_COUNT - 1);
	localparam logic [19:0] AvgMul  = 20'(AVG_COUNT);

	logic            last_q, last_d;
	logic [15:0]     tick_q, tick_d;
	logic [7:0]      phase_q, phase_d;
	logic            ready_q, ready_d;
	logic [7:0]      chg_cnt_q, chg_cnt_d;
	logic [15:0]     first_q, first_d;
	logic [15:0]     origin_q, origin_d;
	logic            start_lvl_q, start_lvl_d;
	logic [19:0]     sum_q, sum_d;
	logic [IdxW-1:0] idx_q, idx_d;
	logic [19:0]     rep_q, rep_d;
	logic [15:0]     dur_q, dur_d;

	logic            edge_w, second_w, chg_w;
	logic            level_change;
	logic            dlv_en, rep_en;
	logic [15:0]     dlv_ticks;
	logic [19:0]     rep_val, sum_new;
	logic [15:0]     tick_base, tick_inc;
	logic [7:0]      phase_base;
	logic [8:0]      phase_inc;

	assign level_change = (pin != last_q);

	// next state for one sample
	always_comb begin
		last_d      = last_q;
		tick_d      = tick_q;
		phase_d     = phase_q;
		ready_d     = ready_q;
		chg_cnt_d   = chg_cnt_q;
		first_d     = first_q;
		origin_d    = origin_q;
		start_lvl_d = start_lvl_q;
		sum_d       = sum_q;
		idx_d       = idx_q;
		rep_d       = rep_q;
		dur_d       = dur_q;
		edge_w      = 1'b0;
		second_w    = 1'b0;
		chg_w       = 1'b0;
		dlv_en      = 1'b0;
		dlv_ticks   = '0;
		rep_en      = 1'b0;
		rep_val     = '0;
		sum_new     = '0;
		tick_base   = tick_q;
		phase_base  = phase_q;
		tick_inc    = '0;
		phase_inc   = '0;

		if (step) begin
			last_d = pin;

			// edge detection: filtered windows or raw edges
			if (cfg.stable_window != '0) begin
				if (level_change) begin
					if (chg_cnt_q == '0)
						first_d = tick_q;
					chg_cnt_d = chg_cnt_q + 8'd1;
				end
				if (phase_q == '0) begin
					start_lvl_d = level_change ? ~pin : pin;
				end else if (phase_q == cfg.stable_window - 8'd1) begin
					if (chg_cnt_d[0] && (start_lvl_q != pin)) begin
						if (pin == cfg.rising_polarity) begin
							edge_w = 1'b1;
							if (ready_q) begin
								dlv_en     = 1'b1;
								dlv_ticks  = first_d - origin_q;
								origin_d   = first_d - tick_q;
								tick_base  = '0;
								phase_base = '0;
							end else begin
								ready_d  = 1'b1;
								origin_d = first_d;
							end
						end else begin
							dur_d    = tick_q - origin_q;
							second_w = 1'b1;
						end
					end
					chg_cnt_d = '0;
				end
			end else if (level_change && (pin == cfg.rising_polarity)) begin
				edge_w = 1'b1;
				if (ready_q) begin
					dlv_en    = 1'b1;
					dlv_ticks = tick_q;
				end else begin
					ready_d = 1'b1;
				end
				tick_base  = '0;
				phase_base = '0;
			end

			// advance the tick counter and the window phase
			tick_inc  = tick_base + 16'd1;
			phase_inc = {1'b0, phase_base} + 9'd1;
			tick_d    = tick_inc;
			if ((tick_inc == '0) || (cfg.stable_window == '0) ||
			    (phase_inc >= {1'b0, cfg.stable_window}))
				phase_d = '0;
			else
				phase_d = phase_inc[7:0];

			// hand the period to the scaler or the running sum
			if (dlv_en) begin
				if (!cfg.average_enable) begin
					rep_en  = 1'b1;
					rep_val = {4'b0, dlv_ticks} * AvgMul;
				end else begin
					sum_new = sum_q + {4'b0, dlv_ticks};
					if (idx_q >= IdxLast) begin
						rep_en  = 1'b1;
						rep_val = sum_new;
						sum_d   = '0;
						idx_d   = '0;
					end else begin
						sum_d = sum_new;
						idx_d = idx_q + IdxW'(1);
					end
				end
			end

			// report only on change
			if (rep_en && (rep_val != rep_q)) begin
				rep_d = rep_val;
				chg_w = 1'b1;
			end

			// drop the measurement state once the timeout is passed (last pin level, start level and half duration are kept)
			if (tick_inc > cfg.timeout_ticks) begin
				tick_d    = '0;
				phase_d   = '0;
				ready_d   = 1'b0;
				chg_cnt_d = '0;
				first_d   = '0;
				origin_d  = '0;
				idx_d     = '0;
				sum_d     = '0;
				if (rep_d != '0) begin
					rep_d = '0;
					chg_w = 1'b1;
				end
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= 1'b0;
			tick_q      <= '0;
			phase_q     <= '0;
			ready_q     <= 1'b0;
			chg_cnt_q   <= '0;
			first_q     <= '0;
			origin_q    <= '0;
			start_lvl_q <= 1'b0;
			sum_q       <= '0;
			idx_q       <= '0;
			rep_q       <= '0;
			dur_q       <= '0;
		end else begin
			last_q      <= last_d;
			tick_q      <= tick_d;
			phase_q     <= phase_d;
			ready_q     <= ready_d;
			chg_cnt_q   <= chg_cnt_d;
			first_q     <= first_d;
			origin_q    <= origin_d;
			start_lvl_q <= start_lvl_d;
			sum_q       <= sum_d;
			idx_q       <= idx_d;
			rep_q       <= rep_d;
			dur_q       <= dur_d;
		end
	end

	// result word, saturating the period to the output width
	always_comb begin
		res.edge_seen        = edge_w;
		res.second_edge_seen = second_w;
		res.half_duration    = dur_d;
		res.period_changed   = chg_w;
		res.period_value     = rep_d[19] ? PERIOD_MAX : rep_d[18:0];
		res.measuring        = ready_d;
	end

`ifndef SYNTHESIS
	a_edges_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(edge_w && second_w))
		else $error("measuring and opposite edge in the same sample");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IdxLast)
		else $error("average index beyond the averaging count");

	a_no_silent_change: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !chg_w) |=> (rep_q == $past(rep_q)))
		else $error("reported period moved without a change flag");
`endif

endmodule
